### rtl/gdnc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gdnc_pkg;

  // pipeline depth, one register per stage
  localparam int NSTG = 8;

  // days in the Gregorian cycles
  localparam int DAYS_400Y = 146097;
  localparam int DAYS_100Y = 36524;
  localparam int DAYS_4Y   = 1461;
  localparam int DAYS_1Y   = 365;

  // last valid day: 31 December 9999
  localparam logic [21:0] COUNT_MAX = 22'd3652058;

  // year bias for encode: 400 years keep every floor division non-negative
  localparam logic [14:0] EYEAR_BIAS = 15'd399;

  // reciprocal constants for exact constant division, rounded up
  localparam int SH400  = 41;
  localparam int SH1461 = 32;
  localparam int SH25   = 20;
  localparam logic [23:0] M400 =
    24'(((64'd1 << SH400) + 64'(DAYS_400Y) - 64'd1) / 64'(DAYS_400Y));
  localparam logic [21:0] M1461 =
    22'(((64'd1 << SH1461) + 64'(DAYS_4Y) - 64'd1) / 64'(DAYS_4Y));
  localparam logic [15:0] M25 =
    16'(((64'd1 << SH25) + 64'd24) / 64'd25);

  // day-of-year offset before each month, two's complement, index 0 and 13..15 odd
  localparam logic [9:0] MONTH_OFFSET [16] = '{
    10'h3ff, 10'h3ff, 10'd30, 10'd58, 10'd89, 10'd119, 10'd150, 10'd180,
    10'd211, 10'd242, 10'd272, 10'd303, 10'd333, 10'd0, 10'd0, 10'd0
  };

  // one word in flight, decode and encode fields side by side
  typedef struct packed {
    logic        kind;
    logic [21:0] dcnt;
    logic        rerr;
    logic [4:0]  q400;
    logic [1:0]  cent;
    logic [17:0] rem;
    logic [4:0]  q4;
    logic [1:0]  y1;
    logic        leap;
    logic        feb60;
    logic [8:0]  doy;
    logic [13:0] year;
    logic [8:0]  wsum;
    logic [2:0]  wday;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [14:0] ey;
    logic [7:0]  eq100;
    logic        einc;
    logic [9:0]  eoff;
    logic [12:0] part;
    logic [22:0] p365;
    logic [3:0]  emon;
    logic [4:0]  eday;
    logic [22:0] ecnt;
    logic [21:0] ecount;
    logic [2:0]  ewday;
  } pipe_t;

  // x mod 7 by folding octal digits (8 is 1 mod 7)
  function automatic logic [2:0] mod7(input logic [23:0] x);
    logic [5:0] s1;
    logic [3:0] s2;
    logic [3:0] s3;
    s1 = '0;
    for (int i = 0; i < 8; i++) begin
      s1 = s1 + 6'(x[3*i +: 3]);
    end
    s2 = 4'(s1[5:3]) + 4'(s1[2:0]);
    s3 = 4'(s2[3]) + 4'(s2[2:0]);
    return (s3 >= 4'd7) ? 3'd0 : s3[2:0];
  endfunction

endpackage

`default_nettype wire

### rtl/gregorian_day_number_codec.sv
`timescale 1ns / 1ps
`default_nettype none

// Proleptic Gregorian day-number codec. Day 0 is Monday 1 January of year 1.
// tuser on the input picks the operation: 0 decodes the day count into year,
// month, day and weekday (the count is echoed), 1 encodes year, month and day
// into a count (year, month and day out read 0). Month and day are not
// checked on encode; a decoded count past 31 December 9999 raises the range
// error flag in the output tuser and still gives the extrapolated date.
// Weekday is 0 for Sunday through 6 for Saturday. The block takes one word
// per clock and passes each through its eight-stage pipeline (reciprocal
// multipliers for the 400-year and 4-year splits, then compare-and-subtract
// stages). Backpressure collapses bubbles stage by stage, so input keeps
// flowing while a result waits until all eight stages hold a word; after that
// input stalls with the output.
module gregorian_day_number_codec
  import gdnc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // day_count_in[21:0], year_in[35:22], month_in[39:36], day_in[44:40], zero
  input  wire logic [47:0] s_axis_tdata,
  // kind: 0 decode, 1 encode
  input  wire logic        s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // day_count_out[21:0], year_out[35:22], month_out[39:36], day_out[44:40],
  // weekday[47:45]
  output logic [47:0]      m_axis_tdata,
  // range_error
  output logic             m_axis_tuser
);

  pipe_t            st_q [NSTG];
  pipe_t            st_d [NSTG];
  logic [NSTG-1:0]  vld_q;
  logic [NSTG-1:0]  rdy;

  logic [14:0] in_ey;
  logic [45:0] prod400;
  logic [28:0] prod25;
  logic [6:0]  s1_r100y;
  logic        s1_eleap;
  logic [37:0] prod1461;
  logic [8:0]  s7_feb_end;
  logic [3:0]  s7_mon;

  // per-stage ready, a stage moves when empty or when the next one moves
  always_comb begin
    rdy[NSTG-1] = !vld_q[NSTG-1] || m_axis_tready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      rdy[i] = !vld_q[i] || rdy[i+1];
    end
  end

  assign s_axis_tready = rdy[0];

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) begin
        vld_q[0] <= s_axis_tvalid;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (rdy[i]) begin
          vld_q[i] <= vld_q[i-1];
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NSTG; i++) begin
      if (rdy[i]) begin
        st_q[i] <= st_d[i];
      end
    end
  end

  // stage 0: capture word, 400-year quotient, encode year over 100
  assign in_ey   = 15'(s_axis_tdata[35:22]) + EYEAR_BIAS;
  assign prod400 = 46'(s_axis_tdata[21:0]) * 46'(M400);
  assign prod25  = 29'(in_ey[14:2]) * 29'(M25);

  always_comb begin
    st_d[0]       = '0;
    st_d[0].kind  = s_axis_tuser;
    st_d[0].dcnt  = s_axis_tdata[21:0];
    st_d[0].q400  = 5'(prod400 >> SH400);
    st_d[0].ey    = in_ey;
    st_d[0].eq100 = 8'(prod25 >> SH25);
    st_d[0].emon  = s_axis_tdata[39:36];
    st_d[0].eday  = s_axis_tdata[44:40];
  end

  // stage 1: remainder in the 400-year cycle, range check, leap test and terms for encode
  assign s1_r100y = 7'(st_q[0].ey - 15'(st_q[0].eq100) * 15'd100);
  assign s1_eleap = (st_q[0].ey[1:0] == 2'd3) &&
                    ((s1_r100y != 7'd99) || (st_q[0].eq100[1:0] == 2'd3));

  always_comb begin
    st_d[1]      = st_q[0];
    st_d[1].rem  = 18'(st_q[0].dcnt - 22'(st_q[0].q400) * 22'(DAYS_400Y));
    st_d[1].rerr = (st_q[0].dcnt > COUNT_MAX);
    st_d[1].einc = s1_eleap && (st_q[0].emon > 4'd2);
    st_d[1].eoff = MONTH_OFFSET[st_q[0].emon];
    st_d[1].part = 13'(st_q[0].ey[14:2]) - 13'(st_q[0].eq100) + 13'(st_q[0].eq100[7:2]);
    st_d[1].p365 = 23'(st_q[0].ey) * 23'(DAYS_1Y);
  end

  // stage 2: century blocks, encode sum
  always_comb begin
    st_d[2] = st_q[1];
    if (st_q[1].rem >= 18'(3 * DAYS_100Y)) begin
      st_d[2].cent = 2'd3;
    end else if (st_q[1].rem >= 18'(2 * DAYS_100Y)) begin
      st_d[2].cent = 2'd2;
    end else if (st_q[1].rem >= 18'(DAYS_100Y)) begin
      st_d[2].cent = 2'd1;
    end else begin
      st_d[2].cent = 2'd0;
    end
    st_d[2].rem  = 18'(st_q[1].rem - 18'(st_d[2].cent) * 18'(DAYS_100Y));
    st_d[2].ecnt = st_q[1].p365 + 23'(st_q[1].part) + {{13{st_q[1].eoff[9]}}, st_q[1].eoff}
                 + 23'(st_q[1].eday) + 23'(st_q[1].einc);
  end

  // stage 3: 4-year quotient, encode count and weekday
  assign prod1461 = 38'(st_q[2].rem[15:0]) * 38'(M1461);

  always_comb begin
    st_d[3]        = st_q[2];
    st_d[3].q4     = 5'(prod1461 >> SH1461);
    st_d[3].ecount = 22'(st_q[2].ecnt - 23'(DAYS_400Y));
    st_d[3].ewday  = mod7(24'(st_q[2].ecnt) + 24'd1);
  end

  // stage 4: remainder in the 4-year block
  always_comb begin
    st_d[4]     = st_q[3];
    st_d[4].rem = 18'(st_q[3].rem - 18'(st_q[3].q4) * 18'(DAYS_4Y));
  end

  // stage 5: single years, year number, leap flag, weekday residue sum
  always_comb begin
    st_d[5] = st_q[4];
    if (st_q[4].rem >= 18'(3 * DAYS_1Y)) begin
      st_d[5].y1 = 2'd3;
    end else if (st_q[4].rem >= 18'(2 * DAYS_1Y)) begin
      st_d[5].y1 = 2'd2;
    end else if (st_q[4].rem >= 18'(DAYS_1Y)) begin
      st_d[5].y1 = 2'd1;
    end else begin
      st_d[5].y1 = 2'd0;
    end
    st_d[5].doy  = 9'(st_q[4].rem - 18'(st_d[5].y1) * 18'(DAYS_1Y));
    st_d[5].year = 14'd1 + 14'(st_q[4].q400) * 14'd400 + 14'(st_q[4].cent) * 14'd100
                 + 14'(st_q[4].q4) * 14'd4 + 14'(st_d[5].y1);
    st_d[5].leap = (st_d[5].y1 == 2'd3) &&
                   ((st_q[4].q4 != 5'd24) || (st_q[4].cent == 2'd3));
    // 36524 and 1461 are 5 mod 7, 365 is 1 mod 7, 146097 is 0 mod 7
    st_d[5].wsum = 9'(st_q[4].cent) * 9'd5 + 9'(st_q[4].q4) * 9'd5 + 9'(st_d[5].y1)
                 + st_d[5].doy + 9'd1;
  end

  // stage 6: leap day correction, decode weekday
  always_comb begin
    st_d[6]       = st_q[5];
    st_d[6].feb60 = st_q[5].leap && (st_q[5].doy < 9'd60);
    if (st_q[5].leap && (st_q[5].doy >= 9'd60)) begin
      st_d[6].doy = st_q[5].doy - 9'd1;
    end
    st_d[6].wday = mod7(24'(st_q[5].wsum));
  end

  // stage 7: month and day, result select
  assign s7_feb_end = st_q[6].feb60 ? 9'd60 : 9'd59;

  always_comb begin
    if (st_q[6].doy < 9'd31) begin
      s7_mon = 4'd1;
    end else if (st_q[6].doy < s7_feb_end) begin
      s7_mon = 4'd2;
    end else if (st_q[6].doy < 9'd90) begin
      s7_mon = 4'd3;
    end else if (st_q[6].doy < 9'd120) begin
      s7_mon = 4'd4;
    end else if (st_q[6].doy < 9'd151) begin
      s7_mon = 4'd5;
    end else if (st_q[6].doy < 9'd181) begin
      s7_mon = 4'd6;
    end else if (st_q[6].doy < 9'd212) begin
      s7_mon = 4'd7;
    end else if (st_q[6].doy < 9'd243) begin
      s7_mon = 4'd8;
    end else if (st_q[6].doy < 9'd273) begin
      s7_mon = 4'd9;
    end else if (st_q[6].doy < 9'd304) begin
      s7_mon = 4'd10;
    end else if (st_q[6].doy < 9'd334) begin
      s7_mon = 4'd11;
    end else begin
      s7_mon = 4'd12;
    end
  end

  always_comb begin
    st_d[7]       = st_q[6];
    st_d[7].month = s7_mon;
    st_d[7].day   = 5'(10'(st_q[6].doy) - MONTH_OFFSET[s7_mon]);
    if (st_q[6].kind) begin
      st_d[7].dcnt  = st_q[6].ecount;
      st_d[7].year  = '0;
      st_d[7].month = '0;
      st_d[7].day   = '0;
      st_d[7].wday  = st_q[6].ewday;
      st_d[7].rerr  = 1'b0;
    end
  end

  // output word
  assign m_axis_tvalid = vld_q[NSTG-1];
  assign m_axis_tdata  = {st_q[NSTG-1].wday, st_q[NSTG-1].day, st_q[NSTG-1].month,
                          st_q[NSTG-1].year, st_q[NSTG-1].dcnt};
  assign m_axis_tuser  = st_q[NSTG-1].rerr;

  // decoded dates are well formed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !st_q[NSTG-1].kind) |->
      (st_q[NSTG-1].month >= 4'd1) && (st_q[NSTG-1].month <= 4'd12) &&
      (st_q[NSTG-1].day >= 5'd1) && (st_q[NSTG-1].wday <= 3'd6))
    else $error("decoded date out of range");

  // range error only on decode and only past year 9999
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |->
      (!st_q[NSTG-1].kind && (st_q[NSTG-1].year > 14'd9999)))
    else $error("range error flag inconsistent with result");

  // an empty pipeline always takes a word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q == '0) |-> s_axis_tready)
    else $error("empty pipeline refuses input");

endmodule

`default_nettype wire

### tb/sv/gregorian_day_number_codec_tb.sv
`timescale 1ns / 1ps

module gregorian_day_number_codec_tb;

  typedef enum logic {
    OP_DECODE = 1'b0,
    OP_ENCODE = 1'b1
  } op_e;

  // one result word as the block returns it
  typedef struct packed {
    logic [21:0] count;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [2:0]  wday;
    logic        rerr;
  } date_word_t;

  localparam int LAST_COUNT   = 3652058;
  localparam int STALL_LIMIT  = 4000;
  localparam int HOLD_CYCLES  = 500;
  localparam int RANDOM_WORDS = 1000;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata  = '0;
  logic        s_axis_tuser  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tuser;

  date_word_t expected_dates[$];
  int         error_count  = 0;
  int         n_decode     = 0;
  int         n_encode     = 0;
  int         n_past_range = 0;
  int         n_checked    = 0;
  int         burst_left   = 0;
  logic       hold_request = 1'b0;

  gregorian_day_number_codec DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- calendar math

  function automatic bit is_leap(input int yr);
    return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
  endfunction

  // days in the year before day 1 of the month, less one; odd values for 0 and 13..15
  function automatic int days_before_month(input int mon);
    case (mon)
      0, 1:    return -1;
      2:       return 30;
      3:       return 58;
      4:       return 89;
      5:       return 119;
      6:       return 150;
      7:       return 180;
      8:       return 211;
      9:       return 242;
      10:      return 272;
      11:      return 303;
      12:      return 333;
      default: return 0;
    endcase
  endfunction

  // 0 sunday, day 0 is a monday, floored for negative counts
  function automatic logic [2:0] weekday_from(input longint cnt);
    longint w;
    w = (cnt + 1) % 7;
    if (w < 0) begin
      w = w + 7;
    end
    return 3'(w);
  endfunction

  // exact day count of a date, may be negative for year 0
  function automatic longint days_from_date(input int yr, input int mon, input int dy);
    longint y;
    longint leaps;
    longint c;
    y = yr - 1;
    leaps = (y < 0) ? -1 : (y / 4 - y / 100 + y / 400);
    c = y * 365 + leaps + days_before_month(mon) + dy;
    if (mon > 2 && is_leap(yr)) begin
      c = c + 1;
    end
    return c;
  endfunction

  function automatic date_word_t calendar_result(input op_e op, input logic [21:0] cnt,
                                                 input logic [13:0] yr,
                                                 input logic [3:0] mon,
                                                 input logic [4:0] dy);
    date_word_t r;
    int         d;
    int         q;
    int         year;
    int         m;
    int         feb_end;
    longint     c;
    r = '0;
    if (op == OP_DECODE) begin
      d = int'(cnt);
      r.count = cnt;
      r.wday  = weekday_from(d);
      r.rerr  = (d > LAST_COUNT);
      // 400-year cycles, then centuries, 4-year blocks and single years
      q = d / 146097;
      d = d - q * 146097;
      year = 1 + q * 400;
      for (int i = 0; i < 3 && d >= 36524; i++) begin
        d = d - 36524;
        year = year + 100;
      end
      q = d / 1461;
      d = d - q * 1461;
      year = year + q * 4;
      for (int i = 0; i < 3 && d >= 365; i++) begin
        d = d - 365;
        year = year + 1;
      end
      // leap day folds into february
      feb_end = 59;
      if (is_leap(year)) begin
        if (d >= 60) begin
          d = d - 1;
        end else begin
          feb_end = 60;
        end
      end
      if (d < 31) begin
        m = 1;
      end else if (d < feb_end) begin
        m = 2;
      end else begin
        m = 3;
        while (m < 12 && d > days_before_month(m + 1)) m++;
      end
      r.year  = 14'(year);
      r.month = 4'(m);
      r.day   = 5'(d - days_before_month(m));
    end else begin
      c = days_from_date(int'(yr), int'(mon), int'(dy));
      r.count = 22'(c);
      r.wday  = weekday_from(c);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- sender

  task automatic send_word(input op_e op, input int cnt, input int yr, input int mon,
                           input int dy);
    int gap;
    // bursts of random length, random gaps in between
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {3'b000, 5'(dy), 4'(mon), 14'(yr), 22'(cnt)};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_dates.push_back(calendar_result(op, 22'(cnt), 14'(yr), 4'(mon), 5'(dy)));
    if (op == OP_DECODE) begin
      n_decode++;
      if (22'(cnt) > 22'(LAST_COUNT)) begin
        n_past_range++;
      end
    end else begin
      n_encode++;
    end
  endtask

  // stop offering and wait for every pending result
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (expected_dates.size() != 0);
  endtask

  task automatic send_decode_of(input int yr, input int mon, input int dy, input int delta);
    send_word(OP_DECODE, int'(days_from_date(yr, mon, dy)) + delta,
              $urandom_range(0, 16383), $urandom_range(0, 15), $urandom_range(0, 31));
  endtask

  task automatic send_encode(input int yr, input int mon, input int dy);
    send_word(OP_ENCODE, $urandom_range(0, 4194303), yr, mon, dy);
  endtask

  // ---------------------------------------------------------------- tests

  // month ends, century rules, cycle edges, last valid day and beyond
  task automatic test_decode_corners();
    send_decode_of(1, 1, 1, 0);
    send_decode_of(1, 2, 28, 0);
    send_decode_of(1, 3, 1, 0);
    send_decode_of(4, 12, 31, 0);
    send_decode_of(100, 12, 31, 0);
    send_decode_of(400, 12, 31, 0);
    send_decode_of(401, 1, 1, 0);
    send_decode_of(1900, 2, 28, 0);
    send_decode_of(1900, 3, 1, 0);
    send_decode_of(2000, 2, 29, 0);
    send_decode_of(2000, 3, 1, 0);
    send_decode_of(9999, 12, 31, 0);
    send_decode_of(9999, 12, 31, 1);
    send_word(OP_DECODE, 4194303, 0, 0, 0);
  endtask

  // year 0, out-of-table months, day 0 and the widest fields
  task automatic test_encode_corners();
    send_encode(1, 1, 1);
    send_encode(9999, 12, 31);
    send_encode(0, 1, 1);
    send_encode(0, 3, 1);
    send_encode(16383, 15, 31);
    send_encode(2000, 2, 29);
    send_encode(2000, 3, 1);
    send_encode(1900, 3, 1);
    send_encode(2024, 0, 0);
    send_encode(2024, 13, 5);
    send_encode(400, 14, 31);
    send_encode(1, 12, 0);
  endtask

  // receiver holds off while words keep coming, so the pipe backs up
  task automatic test_output_hold();
    s_axis_tvalid <= 1'b0;
    hold_request  <= 1'b1;
    @(posedge clk_i);
    hold_request <= 1'b0;
    for (int i = 0; i < 40; i++) begin
      send_decode_of($urandom_range(1, 9999), $urandom_range(1, 12),
                     $urandom_range(1, 28), 0);
    end
  endtask

  // sender goes quiet until everything is back, then resumes
  task automatic test_pause_drained();
    drain_results();
    for (int i = 0; i < 10; i++) begin
      send_encode($urandom_range(1, 9999), $urandom_range(1, 12), $urandom_range(1, 31));
    end
  endtask

  task automatic random_year(output int yr);
    case ($urandom_range(0, 4))
      0:       yr = 100 * $urandom_range(1, 99);
      1:       yr = 4 * $urandom_range(1, 2499);
      default: yr = $urandom_range(1, 9999);
    endcase
  endtask

  task automatic test_random_mix();
    int yr;
    int pick;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 300 == 299) begin
        drain_results();
      end
      pick = $urandom_range(0, 99);
      random_year(yr);
      if (pick < 30) begin
        send_word(OP_DECODE, $urandom_range(0, LAST_COUNT), $urandom_range(0, 16383),
                  $urandom_range(0, 15), $urandom_range(0, 31));
      end else if (pick < 40) begin
        send_word(OP_DECODE, $urandom_range(0, 4194303), $urandom_range(0, 16383),
                  $urandom_range(0, 15), $urandom_range(0, 31));
      end else if (pick < 52) begin
        // near a month or year boundary
        send_decode_of(yr, $urandom_range(1, 12), 1, int'($urandom_range(0, 4)) - 2);
      end else if (pick < 88) begin
        send_encode(yr, $urandom_range(1, 12), $urandom_range(1, 31));
      end else begin
        send_encode($urandom_range(0, 16383), $urandom_range(0, 15), $urandom_range(0, 31));
      end
    end
  endtask

  // ---------------------------------------------------------------- receiver

  always @(posedge clk_i) begin
    int hold_left;
    int mode;
    int mode_left;
    if (hold_request && hold_left == 0) begin
      hold_left = HOLD_CYCLES;
    end
    if (mode_left == 0) begin
      mode = $urandom_range(0, 3);
      mode_left = $urandom_range(50, 150);
    end
    mode_left--;
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      case (mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= $urandom_range(0, 1);
        2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
        default: m_axis_tready <= ~m_axis_tready;
      endcase
    end
  end

  // ---------------------------------------------------------------- checking

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin
    date_word_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_dates.size() == 0) begin
        $error("result word with no pending expectation");
        error_count++;
      end else begin
        want = expected_dates.pop_front();
        n_checked++;
        check_field("day_count_out", want.count, m_axis_tdata[21:0]);
        check_field("year_out", want.year, m_axis_tdata[35:22]);
        check_field("month_out", want.month, m_axis_tdata[39:36]);
        check_field("day_out", want.day, m_axis_tdata[44:40]);
        check_field("weekday", want.wday, m_axis_tdata[47:45]);
        check_field("range_error", want.rerr, m_axis_tuser);
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk_i) begin
    int quiet;
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet = 0;
    end else begin
      quiet++;
    end
    if (quiet >= STALL_LIMIT) begin
      $display("timeout: no word accepted for %0d cycles", STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_decode_corners();
    test_encode_corners();
    test_output_hold();
    test_pause_drained();
    test_random_mix();
    drain_results();
    repeat (gdnc_pkg::NSTG + 4) @(posedge clk_i);
    if (expected_dates.size() != 0) begin
      $error("%0d expected results never arrived", expected_dates.size());
      error_count++;
    end
    $display("covered %0d decodes (%0d past year 9999) and %0d encodes, %0d results checked",
             n_decode, n_past_range, n_encode, n_checked);
    $display("with output hold-off, drain pauses, bursty input and random output stalls");
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/gdnc_pkg.sv
rtl/gregorian_day_number_codec.sv
tb/sv/gregorian_day_number_codec_tb.sv
